[rtl/core/pmml_pkg.sv]
// ----------------------------------------------------------------------------
// pmml_pkg
// Shared types and constants for the prefix match min length block.
// ----------------------------------------------------------------------------
`default_nettype none

package pmml_pkg;

    localparam int unsigned CFG_INDEX_W = 4;
    localparam int unsigned CFG_DATA_W  = 64;
    localparam int unsigned LEN_W       = 5;
    localparam int unsigned START_W     = 32;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LOW  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_HIGH = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LEN  = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_LEN      = 4'd3;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in;

    typedef struct packed {
        logic [START_W-1:0] match_start;
        logic [LEN_W-1:0]   match_length;
        logic               last_match;
    } t_out;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic hits;
        logic last;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

[rtl/core/pmml_ctrl.sv]
// ----------------------------------------------------------------------------
// pmml_ctrl
// Controller: takes a request, then walks the datapath through its matches.
// ----------------------------------------------------------------------------
`default_nettype none

module pmml_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire pmml_pkg::t_status i_status,
    output pmml_pkg::t_cmd         o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic r_state;
    logic n_state;

    assign o_in_stall = (r_state == ST_EMIT);

    always_comb begin
        o_cmd.load = i_in_valid && (r_state == ST_IDLE);
        o_cmd.emit = (r_state == ST_EMIT) && i_status.out_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.load && i_status.hits) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (o_cmd.emit && i_status.last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

[rtl/core/pmml_dp.sv]
// ----------------------------------------------------------------------------
// pmml_dp
// Datapath: config registers, live prefix vector, position and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pmml_dp #(
    parameter int unsigned PATTERN_MAX   = 16,
    parameter int unsigned POSITION_BITS = 32
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [pmml_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  wire logic [pmml_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  wire pmml_pkg::t_in                         i_in_data,
    input  wire pmml_pkg::t_cmd                        i_cmd,
    output pmml_pkg::t_status                          o_status,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output pmml_pkg::t_out                             o_out_data
);

    localparam int unsigned IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int unsigned LEN_W = pmml_pkg::LEN_W;

    logic [63:0]              r_pat_low;
    logic [63:0]              r_pat_high;
    logic [LEN_W-1:0]         r_pat_len;
    logic [LEN_W-1:0]         r_min_len;

    logic [PATTERN_MAX-1:0]   r_live;
    logic [PATTERN_MAX-1:0]   r_pend;
    logic [POSITION_BITS-1:0] r_pos;
    logic [POSITION_BITS-1:0] r_epos;
    logic                     r_ov;
    pmml_pkg::t_out           r_out;

    logic [LEN_W-1:0]         m_eff;
    logic [LEN_W-1:0]         lmin_eff;
    logic [PATTERN_MAX-1:0]   eq;
    logic [PATTERN_MAX-1:0]   rep_mask;
    logic [PATTERN_MAX:0]     shifted;
    logic [PATTERN_MAX-1:0]   n_live;
    logic [PATTERN_MAX-1:0]   n_pend_hits;
    logic [IDX_W-1:0]         top_idx;
    logic [PATTERN_MAX-1:0]   pend_rest;
    logic [POSITION_BITS-1:0] idx_ext;
    logic [POSITION_BITS-1:0] start;

    always_comb begin
        m_eff = (r_pat_len > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : r_pat_len;
        lmin_eff = (r_min_len == '0) ? LEN_W'(1) : r_min_len;
    end

    // per-position byte compare and report window
    always_comb begin
        for (int k = 0; k < PATTERN_MAX; k++) begin
            logic [7:0] pb;
            if (k < 8) begin
                pb = r_pat_low[8*k +: 8];
            end else begin
                pb = r_pat_high[8*(k-8) +: 8];
            end
            eq[k] = (LEN_W'(k) < m_eff) && (pb == i_in_data.text_byte);
            rep_mask[k] = (LEN_W'(k + 1) >= lmin_eff);
        end
    end

    assign shifted     = {r_live, 1'b1};
    assign n_live      = shifted[PATTERN_MAX-1:0] & eq;
    assign n_pend_hits = n_live & rep_mask;

    // longest pending match first
    always_comb begin
        top_idx = '0;
        for (int k = 0; k < PATTERN_MAX; k++) begin
            if (r_pend[k]) begin
                top_idx = IDX_W'(k);
            end
        end
        pend_rest = r_pend;
        pend_rest[top_idx] = 1'b0;
    end

    assign idx_ext = POSITION_BITS'(top_idx);
    assign start   = (r_epos >= idx_ext) ? (r_epos - idx_ext) : '0;

    always_comb begin
        o_status.hits     = (n_pend_hits != '0);
        o_status.last     = (pend_rest == '0);
        o_status.out_free = !r_ov || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_pat_len  <= LEN_W'(1);
            r_min_len  <= LEN_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pmml_pkg::CFG_PATTERN_LOW:  r_pat_low  <= i_cfg_data;
                pmml_pkg::CFG_PATTERN_HIGH: r_pat_high <= i_cfg_data;
                pmml_pkg::CFG_PATTERN_LEN:  r_pat_len  <= i_cfg_data[LEN_W-1:0];
                pmml_pkg::CFG_MIN_LEN:      r_min_len  <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= '0;
            r_pos  <= '0;
            r_pend <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_pend <= n_pend_hits;
                if (i_in_data.end_of_text) begin
                    r_live <= '0;
                    r_pos  <= '0;
                end else begin
                    r_live <= n_live;
                    if (r_pos != '1) begin
                        r_pos <= r_pos + POSITION_BITS'(1);
                    end
                end
            end else if (i_cmd.emit) begin
                r_pend <= pend_rest;
            end
            if (i_cmd.emit) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_epos <= r_pos;
        end
        if (i_cmd.emit) begin
            r_out.match_start  <= pmml_pkg::START_W'(start);
            r_out.match_length <= LEN_W'(top_idx) + LEN_W'(1);
            r_out.last_match   <= (pend_rest == '0);
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

[rtl/core/prefix_match_min_length_top.sv]
// ----------------------------------------------------------------------------
// prefix_match_min_length_top
// Streaming shift-and prefix matcher reporting matches of a minimum length.
// ----------------------------------------------------------------------------
// a byte with no reportable match does not stall the input; one request per
// cycle while o_in_stall is low; a byte with n reportable matches stalls the
// input until all n are emitted (one result a cycle through the single result
// register while i_out_stall is low); each result passes r_pend, then r_out
// reset clears the live prefixes, position and config to their reset values
`default_nettype none

module prefix_match_min_length_top #(
    parameter int unsigned PATTERN_MAX   = 16,
    parameter int unsigned POSITION_BITS = 32
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire pmml_pkg::t_in                    i_in_data,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output pmml_pkg::t_out                        o_out_data,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [pmml_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [pmml_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    pmml_pkg::t_cmd    cmd;
    pmml_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    pmml_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    pmml_dp #(
        .PATTERN_MAX   (PATTERN_MAX),
        .POSITION_BITS (POSITION_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
